// ===== hdl/usph_pkg.sv =====
// Shared constants, register codes and sine table helper for the UV-sphere vertex unit.
package usph_pkg;

    localparam int STACKS_DEF     = 10;
    localparam int PHASE_BITS_DEF = 12;

    localparam int RADIUS_W = 16;
    localparam int SLICES_W = 10;
    localparam int STACK_W  = 6;
    localparam int COORD_W  = 17;
    localparam int SINE_W   = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [SLICES_W-1:0] SLICES_RST = 10'd100;

    // register select bit (byte address bit 2)
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_SLICES = 1'b1;

    localparam real PI_R = 3.14159265358979323846;

    // round(32767*sin(r*step)), quarter wave magnitude
    function automatic logic [SINE_W-2:0] f_quarter_sine(input int r, input real step);
        real v;
        int  iv;
        v  = 32767.0 * $sin(step * real'(r));
        iv = int'(v);
        if (iv > 32767) begin
            iv = 32767;
        end
        return (SINE_W-1)'(iv);
    endfunction

endpackage

// ===== hdl/uv_sphere_triangle_vertices_unit.sv =====
// UV-sphere cell tessellator: one (stack, slice) cell in, six triangle vertices out.
// A cell is taken every cycle while o_in_ready is high, into a divider pipeline of
// PHASE_BITS+1 stages that forms the azimuth phases one quotient bit per stage; a vertex
// sequencer then issues one vertex per cycle while the output is not stalled by i_out_ready,
// into a three-stage sine/multiply pipeline; on the single result channel a valid cell
// gives six vertices and a bad index one.
module uv_sphere_triangle_vertices_unit #(
    parameter int STACKS     = usph_pkg::STACKS_DEF,
    parameter int PHASE_BITS = usph_pkg::PHASE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [usph_pkg::APB_AW-1:0]              paddr,
    input  logic [usph_pkg::APB_DW-1:0]              pwdata,
    output logic [usph_pkg::APB_DW-1:0]              prdata,
    output logic                                     pready,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [usph_pkg::STACK_W-1:0]             i_stack_index,
    input  logic [usph_pkg::SLICES_W-1:0]            i_slice_index,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [usph_pkg::COORD_W-1:0]      o_vert_x,
    output logic signed [usph_pkg::COORD_W-1:0]      o_vert_y,
    output logic signed [usph_pkg::COORD_W-1:0]      o_vert_z,
    output logic                                     o_last_vertex,
    output logic                                     o_bad_index
);
    import usph_pkg::*;

    localparam int PB       = PHASE_BITS;
    localparam int HALF     = 1 << (PB - 1);
    localparam int Q        = 1 << (PB - 2);
    localparam int JW       = $clog2(STACKS + 1);
    localparam int RW       = SLICES_W + 1;
    localparam int POL_STEP = HALF / STACKS;
    localparam int POL_FRAC = HALF % STACKS;

    typedef logic [PB-1:0] t_pol_tab [STACKS+1];

    // floor(k*HALF/STACKS), built by stepping quotient and remainder
    function automatic t_pol_tab f_pol();
        t_pol_tab t;
        int       q;
        int       rem;
        q   = 0;
        rem = 0;
        for (int k = 0; k <= STACKS; k++) begin
            t[k] = PB'(q);
            q    = q + POL_STEP;
            rem  = rem + POL_FRAC;
            if (rem >= STACKS) begin
                rem = rem - STACKS;
                q   = q + 1;
            end
        end
        return t;
    endfunction

    localparam t_pol_tab POL_TAB = f_pol();

    // ---------------- configuration ----------------
    logic [RADIUS_W-1:0] r_radius;
    logic [SLICES_W-1:0] r_slices;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_slices <= SLICES_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_RADIUS: r_radius <= pwdata[RADIUS_W-1:0];
                REG_SLICES: r_slices <= pwdata[SLICES_W-1:0];
                default:    r_radius <= r_radius;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RADIUS: prdata = {{(APB_DW-RADIUS_W){1'b0}}, r_radius};
            REG_SLICES: prdata = {{(APB_DW-SLICES_W){1'b0}}, r_slices};
            default:    prdata = '0;
        endcase
    end

    // ---------------- divider pipeline ----------------
    logic          r_fv    [PB+1];
    logic          r_fbad  [PB+1];
    logic          r_fwrap [PB+1];
    logic [PB-1:0] r_fp0   [PB+1];
    logic [PB-1:0] r_fp1   [PB+1];
    logic [RW-1:0] r_frem0 [PB+1];
    logic [RW-1:0] r_frem1 [PB+1];
    logic [PB-1:0] r_fq0   [PB+1];
    logic [PB-1:0] r_fq1   [PB+1];

    logic          f_adv;
    logic          em_take;
    logic          in_bad;
    logic [JW-1:0] j_idx;
    logic [RW-1:0] i_next;

    assign f_adv      = !r_fv[PB] || em_take;
    assign o_in_ready = f_adv;

    assign in_bad = ({1'b0, i_stack_index} >= 7'(STACKS)) || (i_slice_index >= r_slices);
    assign j_idx  = in_bad ? '0 : JW'(i_stack_index);
    assign i_next = {1'b0, i_slice_index} + RW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv[0] <= 1'b0;
        end else if (f_adv) begin
            r_fv[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_fbad[0]  <= in_bad;
            r_fwrap[0] <= (i_next == {1'b0, r_slices});
            r_fp0[0]   <= POL_TAB[j_idx];
            r_fp1[0]   <= POL_TAB[j_idx + JW'(1)];
            r_frem0[0] <= {1'b0, i_slice_index};
            r_frem1[0] <= i_next;
            r_fq0[0]   <= '0;
            r_fq1[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= PB; s++) begin : g_div
        logic [RW:0] sh0, sh1;
        logic        ge0, ge1;

        assign sh0 = {r_frem0[s-1], 1'b0};
        assign sh1 = {r_frem1[s-1], 1'b0};
        assign ge0 = sh0 >= {2'b00, r_slices};
        assign ge1 = sh1 >= {2'b00, r_slices};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fv[s] <= 1'b0;
            end else if (f_adv) begin
                r_fv[s] <= r_fv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (f_adv) begin
                r_fbad[s]  <= r_fbad[s-1];
                r_fwrap[s] <= r_fwrap[s-1];
                r_fp0[s]   <= r_fp0[s-1];
                r_fp1[s]   <= r_fp1[s-1];
                r_frem0[s] <= ge0 ? RW'(sh0 - {2'b00, r_slices}) : RW'(sh0);
                r_frem1[s] <= ge1 ? RW'(sh1 - {2'b00, r_slices}) : RW'(sh1);
                r_fq0[s]   <= {r_fq0[s-1][PB-2:0], ge0};
                r_fq1[s]   <= {r_fq1[s-1][PB-2:0], ge1};
            end
        end
    end

    // ---------------- vertex sequencer ----------------
    logic          r_em_v;
    logic          r_em_bad;
    logic [2:0]    r_k;
    logic [PB-1:0] r_p0, r_p1, r_a0, r_a1;
    logic          b_adv;
    logic          em_done;
    logic          sel_p1, sel_a1;
    logic [PB-1:0] pol_ph, az_ph;

    assign em_done = r_em_bad || (r_k == 3'd5);
    assign em_take = !r_em_v || (b_adv && em_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_v <= 1'b0;
            r_k    <= '0;
        end else if (em_take) begin
            r_em_v <= r_fv[PB];
            r_k    <= '0;
        end else if (b_adv) begin
            r_k <= r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_take) begin
            r_em_bad <= r_fbad[PB];
            r_p0     <= r_fp0[PB];
            r_p1     <= r_fp1[PB];
            r_a0     <= r_fq0[PB];
            r_a1     <= r_fwrap[PB] ? '0 : r_fq1[PB];
        end
    end

    // vertex order: (p0,a0) (p1,a1) (p0,a1) (p0,a0) (p1,a0) (p1,a1)
    assign sel_p1 = (r_k == 3'd1) || (r_k == 3'd4) || (r_k == 3'd5);
    assign sel_a1 = (r_k == 3'd1) || (r_k == 3'd2) || (r_k == 3'd5);
    assign pol_ph = sel_p1 ? r_p1 : r_p0;
    assign az_ph  = sel_a1 ? r_a1 : r_a0;

    // ---------------- sine lookup stage ----------------
    logic signed [SINE_W-1:0] sin_pol, cos_pol, sin_az, cos_az;
    logic                     r_rv, r_rlast, r_rbad;

    usph_sin_rom #(.PHASE_BITS(PB)) u_rom_pol (
        .i_clk     (i_clk),
        .i_en      (b_adv),
        .i_phase_a (pol_ph),
        .i_phase_b (pol_ph + PB'(Q)),
        .o_sin_a   (sin_pol),
        .o_sin_b   (cos_pol)
    );

    usph_sin_rom #(.PHASE_BITS(PB)) u_rom_az (
        .i_clk     (i_clk),
        .i_en      (b_adv),
        .i_phase_a (az_ph),
        .i_phase_b (az_ph + PB'(Q)),
        .o_sin_a   (sin_az),
        .o_sin_b   (cos_az)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (b_adv) begin
            r_rv <= r_em_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_rlast <= em_done;
            r_rbad  <= r_em_bad;
        end
    end

    // ---------------- radius multiply stage ----------------
    logic                      r_mv, r_mlast, r_mbad;
    logic signed [COORD_W-1:0] r_my, r_mring;
    logic signed [SINE_W-1:0]  r_msa, r_mca;
    logic signed [2*COORD_W-2:0] prod_y, prod_ring;

    assign prod_y    = $signed({1'b0, r_radius}) * cos_pol;
    assign prod_ring = $signed({1'b0, r_radius}) * sin_pol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (b_adv) begin
            r_mv <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_mlast <= r_rlast;
            r_mbad  <= r_rbad;
            r_my    <= prod_y[31:15];
            r_mring <= prod_ring[31:15];
            r_msa   <= sin_az;
            r_mca   <= cos_az;
        end
    end

    // ---------------- azimuth multiply / output stage ----------------
    logic                        r_ov, r_olast, r_obad;
    logic signed [COORD_W-1:0]   r_ox, r_oy, r_oz;
    logic signed [2*COORD_W-2:0] prod_x, prod_z;

    assign b_adv  = !r_ov || i_out_ready;
    assign prod_x = r_mring * r_msa;
    assign prod_z = r_mring * r_mca;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (b_adv) begin
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_olast <= r_mlast;
            r_obad  <= r_mbad;
            r_ox    <= r_mbad ? '0 : prod_x[31:15];
            r_oy    <= r_mbad ? '0 : r_my;
            r_oz    <= r_mbad ? '0 : prod_z[31:15];
        end
    end

    assign o_out_valid   = r_ov;
    assign o_vert_x      = r_ox;
    assign o_vert_y      = r_oy;
    assign o_vert_z      = r_oz;
    assign o_last_vertex = r_olast;
    assign o_bad_index   = r_obad;

endmodule

// ===== hdl/usph_sin_rom.sv =====
// Dual-read quarter-wave sine ROM with registered reads, signed Q1.15 output.
module usph_sin_rom #(
    parameter int PHASE_BITS = usph_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [PHASE_BITS-1:0]               i_phase_a,
    input  logic [PHASE_BITS-1:0]               i_phase_b,
    output logic signed [usph_pkg::SINE_W-1:0]  o_sin_a,
    output logic signed [usph_pkg::SINE_W-1:0]  o_sin_b
);
    import usph_pkg::*;

    localparam int  Q    = 1 << (PHASE_BITS - 2);
    localparam int  AW   = PHASE_BITS - 1;
    localparam real STEP = PI_R / 2.0 / real'(Q);

    typedef logic [SINE_W-2:0] t_sin_tab [Q+1];

    function automatic t_sin_tab f_fill();
        t_sin_tab t;
        for (int k = 0; k <= Q; k++) begin
            t[k] = f_quarter_sine(k, STEP);
        end
        return t;
    endfunction

    localparam t_sin_tab SIN_TAB = f_fill();

    logic [AW-1:0]     addr_a, addr_b;
    logic              neg_a, neg_b;
    logic [SINE_W-2:0] r_mag_a, r_mag_b;
    logic              r_neg_a, r_neg_b;

    // fold the phase into the first quadrant
    always_comb begin
        addr_a = {1'b0, i_phase_a[PHASE_BITS-3:0]};
        if (i_phase_a[PHASE_BITS-2]) begin
            addr_a = AW'(Q) - {1'b0, i_phase_a[PHASE_BITS-3:0]};
        end
        neg_a  = i_phase_a[PHASE_BITS-1];
        addr_b = {1'b0, i_phase_b[PHASE_BITS-3:0]};
        if (i_phase_b[PHASE_BITS-2]) begin
            addr_b = AW'(Q) - {1'b0, i_phase_b[PHASE_BITS-3:0]};
        end
        neg_b  = i_phase_b[PHASE_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a <= SIN_TAB[addr_a];
            r_mag_b <= SIN_TAB[addr_b];
            r_neg_a <= neg_a;
            r_neg_b <= neg_b;
        end
    end

    assign o_sin_a = r_neg_a ? -$signed({1'b0, r_mag_a}) : $signed({1'b0, r_mag_a});
    assign o_sin_b = r_neg_b ? -$signed({1'b0, r_mag_b}) : $signed({1'b0, r_mag_b});

endmodule

// ===== tb/tb_uv_sphere_triangle_vertices_unit.sv =====
// Self-checking testbench for the UV-sphere cell tessellator: random cells, APB setup, vertex checks.
module tb_uv_sphere_triangle_vertices_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import usph_pkg::*;

    localparam int NSTACKS   = STACKS_DEF;
    localparam int PBITS     = PHASE_BITS_DEF;
    localparam int TURN      = 1 << PBITS;
    localparam int QUARTER   = TURN / 4;
    localparam int DRAIN     = PBITS + 20;
    localparam int STALL_MAX = 3000;
    localparam logic [APB_AW-1:0] ADDR_RADIUS = {REG_RADIUS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SLICES = {REG_SLICES, 2'b00};

    typedef struct packed {
        logic [STACK_W-1:0]  stack;
        logic [SLICES_W-1:0] slice;
    } cell_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
        logic               bad;
    } vertex_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [STACK_W-1:0]    i_stack_index = '0;
    logic [SLICES_W-1:0]   i_slice_index = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [COORD_W-1:0] o_vert_x, o_vert_y, o_vert_z;
    logic                  o_last_vertex, o_bad_index;

    uv_sphere_triangle_vertices_unit dut (.*);

    cell_t   cell_q[$];
    vertex_t vertex_q[$];
    int      sine_tbl[QUARTER+1];
    longint  radius = 256;
    longint  slices = 100;
    int      fails = 0;
    bit      quiet = 1'b0;
    bit      in_taken = 1'b0;
    int      in_gap = 0, out_gap = 0, stall_cnt = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint sine_of(longint p);
        longint q, r, v;
        p = p & (TURN - 1);
        q = p >> (PBITS - 2);
        r = p & (QUARTER - 1);
        if (q[0]) begin
            r = QUARTER - r;
        end
        v = sine_tbl[r];
        return q[1] ? -v : v;
    endfunction

    function automatic vertex_t vertex_at(longint pol, longint az, bit last);
        vertex_t v;
        longint  y, ring, x, z;
        y    = (radius * sine_of(pol + QUARTER)) >>> 15;
        ring = (radius * sine_of(pol)) >>> 15;
        x    = (ring * sine_of(az)) >>> 15;
        z    = (ring * sine_of(az + QUARTER)) >>> 15;
        v.x = x[COORD_W-1:0];
        v.y = y[COORD_W-1:0];
        v.z = z[COORD_W-1:0];
        v.last = last;
        v.bad = 1'b0;
        return v;
    endfunction

    // Push the vertices one cell is expected to produce.
    task automatic predict_cell(cell_t c);
        longint  j, i, p0, p1, a0, a1;
        vertex_t v;
        j = c.stack;
        i = c.slice;
        if (j >= NSTACKS || i >= slices) begin
            v = '0;
            v.last = 1'b1;
            v.bad = 1'b1;
            vertex_q.push_back(v);
        end else begin
            p0 = (j * (TURN / 2)) / NSTACKS;
            p1 = ((j + 1) * (TURN / 2)) / NSTACKS;
            a0 = ((i * TURN) / slices) & (TURN - 1);
            a1 = (((i + 1) * TURN) / slices) & (TURN - 1);
            vertex_q.push_back(vertex_at(p0, a0, 1'b0));
            vertex_q.push_back(vertex_at(p1, a1, 1'b0));
            vertex_q.push_back(vertex_at(p0, a1, 1'b0));
            vertex_q.push_back(vertex_at(p0, a0, 1'b0));
            vertex_q.push_back(vertex_at(p1, a0, 1'b0));
            vertex_q.push_back(vertex_at(p1, a1, 1'b1));
        end
    endtask

    // Driver: present the next cell once the previous one is taken.
    always @(negedge i_clk) begin
        logic  nxt_valid;
        cell_t c;
        nxt_valid = i_in_valid && !in_taken;
        if (i_rst_n && !nxt_valid) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                in_gap = $urandom_range(1, 16);
            end else if (cell_q.size() > 0) begin
                c = cell_q.pop_front();
                predict_cell(c);
                i_stack_index <= c.stack;
                i_slice_index <= c.slice;
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;

        if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(1, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        vertex_t e;
        in_taken = i_in_valid && o_in_ready;
        if (o_out_valid && i_out_ready) begin
            if (vertex_q.size() == 0) begin
                $error("vertex with no cell pending: x=%0d y=%0d z=%0d",
                       o_vert_x, o_vert_y, o_vert_z);
                fails++;
            end else begin
                e = vertex_q.pop_front();
                if (o_vert_x !== e.x) begin
                    $error("vert_x expected %0d got %0d", $signed(e.x), o_vert_x);
                    fails++;
                end
                if (o_vert_y !== e.y) begin
                    $error("vert_y expected %0d got %0d", $signed(e.y), o_vert_y);
                    fails++;
                end
                if (o_vert_z !== e.z) begin
                    $error("vert_z expected %0d got %0d", $signed(e.z), o_vert_z);
                    fails++;
                end
                if (o_last_vertex !== e.last) begin
                    $error("last_vertex expected %0b got %0b", e.last, o_last_vertex);
                    fails++;
                end
                if (o_bad_index !== e.bad) begin
                    $error("bad_index expected %0b got %0b", e.bad, o_bad_index);
                    fails++;
                end
            end
        end
        if (in_taken || (o_out_valid && i_out_ready) || psel || !i_rst_n) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
        end
        if (stall_cnt >= STALL_MAX) begin
            $display("uv_sphere_triangle_vertices_unit test failed");
            $finish;
        end
    end

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cell_q.size() > 0 || i_in_valid || vertex_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_shape(longint r, longint s);
        reg_write(ADDR_RADIUS, APB_DW'(r));
        reg_write(ADDR_SLICES, APB_DW'(s));
        radius = r;
        slices = s;
    endtask

    function automatic cell_t rand_cell();
        cell_t c;
        if ($urandom_range(0, 99) < 85 && slices > 0) begin
            c.stack = STACK_W'($urandom_range(0, NSTACKS - 1));
            c.slice = SLICES_W'($urandom_range(0, int'(slices) - 1));
        end else begin
            c.stack = STACK_W'($urandom());
            c.slice = SLICES_W'($urandom());
        end
        return c;
    endfunction

    initial begin
        longint phase_r[7] = '{256, 65535, 0, 1, 40000, 300, 65535};
        longint phase_s[7] = '{100, 1023, 3, 1, 0, 517, 2};
        int     n;
        for (int r = 0; r <= QUARTER; r++) begin
            sine_tbl[r] = int'(32767.0 * $sin(3.14159265358979323846 / 2.0
                                               * real'(r) / real'(QUARTER)));
        end
        sine_tbl[0] = 0;
        sine_tbl[QUARTER] = 32767;
        phase_r[5] = $urandom_range(0, 65535);
        phase_s[5] = $urandom_range(3, 1023);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cells at reset settings: poles, field extremes, out-of-range, wrap.
        cell_q.push_back('{stack: 0, slice: 0});
        cell_q.push_back('{stack: STACK_W'(NSTACKS - 1), slice: 99});
        cell_q.push_back('{stack: STACK_W'(NSTACKS - 1), slice: 0});
        cell_q.push_back('{stack: 0, slice: 99});
        cell_q.push_back('{stack: STACK_W'(NSTACKS), slice: 5});
        cell_q.push_back('{stack: 63, slice: 5});
        cell_q.push_back('{stack: 3, slice: 100});
        cell_q.push_back('{stack: 3, slice: 1023});
        cell_q.push_back('{stack: 63, slice: 1023});
        cell_q.push_back('{stack: 5, slice: 50});
        cell_q.push_back('{stack: 4, slice: 25});
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            set_shape(phase_r[ph], phase_s[ph]);
            if (ph == 6) begin
                quiet = 1'b1;
            end
            if (slices > 0) begin
                // hit the last slice so the azimuth wraps
                cell_q.push_back('{stack: 0, slice: SLICES_W'(slices - 1)});
                cell_q.push_back('{stack: STACK_W'(NSTACKS - 1),
                                   slice: SLICES_W'(slices - 1)});
            end
            n = (ph == 2 || ph == 3) ? 30 : 75;
            for (int k = 0; k < n; k++) begin
                cell_q.push_back(rand_cell());
            end
            wait_drained();
        end

        if (fails == 0) begin
            $display("uv_sphere_triangle_vertices_unit test passed");
        end else begin
            $display("uv_sphere_triangle_vertices_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/usph_pkg.sv
hdl/usph_sin_rom.sv
hdl/uv_sphere_triangle_vertices_unit.sv
tb/tb_uv_sphere_triangle_vertices_unit.sv
